/* sv/qfts_pkg.sv */
// Package for the two-stack queue: sizes, command and status codes, stack op struct.
// No dependencies; imported by the interfaces, the stack module and the top level.
package qfts_pkg;

    localparam int DEPTH  = 16;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_DEQUEUE = 1'b1;

    localparam logic [1:0] ST_ENQUEUED = 2'd0;
    localparam logic [1:0] ST_DEQUEUED = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd999;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [CNT_W-1:0]         cnt_t;

    // One operation on a stack; push and pop are never raised together.
    typedef struct packed {
        logic  push;
        logic  pop;
        data_t wdata;
    } stk_op_t;

endpackage

/* sv/qfts_if.sv */
// Valid/ready channel interfaces for the queue's request and response items.
// Depends on qfts_pkg.
interface qfts_req_if;
    import qfts_pkg::*;

    logic  valid;
    logic  ready;
    logic  command;
    data_t value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

interface qfts_rsp_if;
    import qfts_pkg::*;

    logic       valid;
    logic       ready;
    data_t      value_out;
    logic [1:0] status;

    modport source (output valid, output value_out, output status, input ready);
    modport sink   (input valid, input value_out, input status, output ready);
endinterface

/* sv/qfts_stack.sv */
// Bounded stack: synchronous memory plus fill count, one push or pop per cycle.
// A pop returns the top entry in the registered read data in the cycle after it. Depends on qfts_pkg.
module qfts_stack
(
    input  logic              clk,
    input  logic              rst_n,
    input  qfts_pkg::stk_op_t op,
    output qfts_pkg::cnt_t    count,
    output qfts_pkg::data_t   rdata
);
    import qfts_pkg::*;

    data_t mem [DEPTH];
    data_t rdata_reg;
    cnt_t  count_reg;
    cnt_t  count_next;
    cnt_t  count_dec;

    assign count_dec = count_reg - cnt_t'(1);

    always_comb
    begin
        count_next = count_reg;
        if (op.push)
        begin
            count_next = count_reg + cnt_t'(1);
        end
        else if (op.pop)
        begin
            count_next = count_dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // memory port: write at the fill level, read just below it
    always_ff @(posedge clk)
    begin
        if (op.push)
        begin
            mem[count_reg[ADDR_W-1:0]] <= op.wdata;
        end
        if (op.pop)
        begin
            rdata_reg <= mem[count_dec[ADDR_W-1:0]];
        end
    end

    assign count = count_reg;
    assign rdata = rdata_reg;

endmodule

/* sv/queue_from_two_stacks.sv */
// FIFO queue built from two bounded stacks held in synchronous memories.
// Enqueue, refused enqueue and dequeue of an empty queue load the result register on accept.
// Dequeue with the second stack holding entries: one memory read, then delivery from S_DONE.
// Dequeue that refills the second stack moves every entry of the first through S_XFER,
// one memory read and one memory write per moved entry, then pops in S_POP and delivers.
// Asynchronous active-low reset empties both stacks; memory contents are left as they are.
module queue_from_two_stacks
(
    input  logic       clk,
    input  logic       rst_n,
    qfts_req_if.sink   request,
    qfts_rsp_if.source response
);
    import qfts_pkg::*;

    // sequencer codes
    localparam logic [1:0] S_IDLE = 2'd0;   // ready for a new item
    localparam logic [1:0] S_XFER = 2'd1;   // moving first stack onto second
    localparam logic [1:0] S_POP  = 2'd2;   // issue the pop of the second stack
    localparam logic [1:0] S_DONE = 2'd3;   // popped value in read register, deliver it

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // result register between the sequencer and the response channel
    logic       out_valid_reg;
    data_t      out_value_reg;
    logic [1:0] out_status_reg;
    logic       out_load;
    data_t      out_value_next;
    logic [1:0] out_status_next;
    logic       out_free;

    stk_op_t first_op;
    stk_op_t second_op;
    cnt_t    first_count;
    cnt_t    second_count;
    data_t   first_rdata;
    data_t   second_rdata;

    logic    in_accept;

    qfts_stack u_first
    (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (first_op),
        .count (first_count),
        .rdata (first_rdata)
    );

    qfts_stack u_second
    (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (second_op),
        .count (second_count),
        .rdata (second_rdata)
    );

    // The result slot is free when empty or being taken in this cycle.
    assign out_free      = !out_valid_reg || response.ready;
    assign request.ready = (state_reg == S_IDLE) && out_free;
    assign in_accept     = request.valid && request.ready;

    always_comb
    begin
        state_next      = state_reg;
        first_op        = '{push: 1'b0, pop: 1'b0, wdata: request.value};
        second_op       = '{push: 1'b0, pop: 1'b0, wdata: first_rdata};
        out_load        = 1'b0;
        out_value_next  = '0;
        out_status_next = ST_ENQUEUED;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (request.command == CMD_ENQUEUE)
                    begin
                        // enqueue answers at once, refused when the first stack is full
                        out_load = 1'b1;
                        if (first_count == cnt_t'(DEPTH))
                        begin
                            out_status_next = ST_FULL;
                        end
                        else
                        begin
                            first_op.push   = 1'b1;
                            out_status_next = ST_ENQUEUED;
                        end
                    end
                    else if (second_count != '0)
                    begin
                        second_op.pop = 1'b1;
                        state_next    = S_DONE;
                    end
                    else if (first_count != '0)
                    begin
                        // refill: start popping the first stack
                        first_op.pop = 1'b1;
                        state_next   = S_XFER;
                    end
                    else
                    begin
                        out_load        = 1'b1;
                        out_value_next  = EMPTY_VALUE;
                        out_status_next = ST_EMPTY;
                    end
                end
            end
            S_XFER:
            begin
                // push the entry read last cycle, pop the next one (if any is left) in the same cycle
                second_op.push = 1'b1;
                if (first_count != '0)
                begin
                    first_op.pop = 1'b1;
                end
                else
                begin
                    state_next = S_POP;
                end
            end
            S_POP:
            begin
                second_op.pop = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_value_next  = second_rdata;
                    out_status_next = ST_DEQUEUED;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (response.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_value_reg  <= out_value_next;
            out_status_reg <= out_status_next;
        end
    end

    assign response.valid     = out_valid_reg;
    assign response.value_out = out_value_reg;
    assign response.status    = out_status_reg;

    // Neither stack ever holds more than DEPTH entries.
    a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (first_count <= cnt_t'(DEPTH)) && (second_count <= cnt_t'(DEPTH)))
        else $error("stack count beyond depth");

    // Every transfer cycle adds exactly one entry to the second stack.
    a_xfer_push: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_XFER) |=> (second_count == $past(second_count) + cnt_t'(1)))
        else $error("transfer cycle without push to second stack");

    // A dequeue that has to read memory blocks new items until its result is out.
    a_deq_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (request.command == CMD_DEQUEUE)
            && ((first_count != '0) || (second_count != '0))) |=> !request.ready)
        else $error("new item taken during dequeue");

    // A loaded result never overwrites one still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("result register overwritten");

endmodule

/* tb/tb_queue_from_two_stacks.sv */
// Self-checking testbench for queue_from_two_stacks: directed and random enqueue/dequeue items.
// Depends on qfts_pkg, qfts_req_if/qfts_rsp_if and the queue_from_two_stacks RTL.
module tb_queue_from_two_stacks;
    timeunit 1ns;
    timeprecision 1ps;

    import qfts_pkg::*;

    // Cycles with no handshake on either side before the run is abandoned.
    // The slowest legal pause is a full refill plus a receiver stall and a
    // sender gap, so this is generous.
    localparam int QUIET_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 64;
    localparam int RANDOM_ITEMS = 1425;
    localparam int PRINT_CAP    = 40;

    typedef struct {
        logic  command;
        data_t value;
        bit    hold_for_drain;   // present only once every result is back
    } queue_req_t;

    typedef struct {
        data_t      value_out;
        logic [1:0] status;
    } queue_rsp_t;

    logic clk;
    logic rst_n;

    qfts_req_if req_ch ();
    qfts_rsp_if rsp_ch ();

    queue_from_two_stacks DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (req_ch),
        .response (rsp_ch)
    );

    // Items waiting to be presented, and results still owed by the block.
    queue_req_t pending_items[$];
    queue_rsp_t owed_results[$];

    // Shadow of the two stacks: pushes land on the entry stack, pops come
    // from the exit stack, which is refilled (reversed) only when empty.
    data_t entry_stack[DEPTH];
    data_t exit_stack[DEPTH];
    int    entry_count;
    int    exit_count;

    int  error_count;
    int  result_count;
    int  refill_count;
    int  status_seen[4];
    int  quiet_cycles;
    bit  drained;        // registered view of "nothing owed", read by the driver
    bit  timed_out;

    // Sender and receiver pacing.
    int  burst_left;
    int  gap_left;
    int  ready_hold;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor: one result per item, worked out on the shadow stacks.
    // ------------------------------------------------------------------
    function automatic queue_rsp_t predict_queue_op(logic command, data_t value);
        queue_rsp_t r;
        if (command == CMD_ENQUEUE)
        begin
            r.value_out = '0;
            if (entry_count >= DEPTH)
                r.status = ST_FULL;       // refused even if the exit stack has room
            else
            begin
                entry_stack[entry_count] = value;
                entry_count++;
                r.status = ST_ENQUEUED;
            end
        end
        else if (entry_count == 0 && exit_count == 0)
        begin
            r.value_out = EMPTY_VALUE;
            r.status    = ST_EMPTY;
        end
        else
        begin
            if (exit_count == 0)
            begin
                refill_count++;
                while (entry_count > 0 && exit_count < DEPTH)
                begin
                    entry_count--;
                    exit_stack[exit_count] = entry_stack[entry_count];
                    exit_count++;
                end
            end
            exit_count--;
            r.value_out = exit_stack[exit_count];
            r.status    = ST_DEQUEUED;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what);
        if (error_count < PRINT_CAP)
            $display("[%0t] mismatch on result %0d: %s", $realtime, result_count, what);
        error_count++;
    endtask

    task automatic add_item(logic command, data_t value, bit hold_for_drain);
        queue_req_t it;
        it.command        = command;
        it.value          = value;
        it.hold_for_drain = hold_for_drain;
        pending_items.push_back(it);
    endtask

    // Value mix: edges of the range, the empty marker as real data, small
    // numbers and full-width random words.
    function automatic data_t pick_value();
        case ($urandom_range(0, 9))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return EMPTY_VALUE;
            3: return data_t'($urandom_range(0, 15)) - 32'sd8;
            default: return data_t'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents queued items in bursts separated by random gaps.
    // valid only drops once the current item has been taken.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid   <= 1'b0;
            req_ch.command <= CMD_ENQUEUE;
            req_ch.value   <= '0;
            burst_left     = 0;
            gap_left       = 0;
        end
        else if (req_ch.valid && !req_ch.ready)
        begin
            // item still on offer; hold it
        end
        else if (gap_left > 0)
        begin
            gap_left--;
            req_ch.valid <= 1'b0;
        end
        else if (pending_items.size() == 0
                 || (pending_items[0].hold_for_drain && !(drained && !req_ch.valid)))
        begin
            // nothing to send, or a pause until every owed result is back
            req_ch.valid <= 1'b0;
        end
        else
        begin
            queue_req_t it;
            it = pending_items.pop_front();
            req_ch.valid   <= 1'b1;
            req_ch.command <= it.command;
            req_ch.value   <= it.value;
            if (burst_left > 0)
                burst_left--;
            else
            begin
                // new burst; a third of them run on with no gap at all
                burst_left = $urandom_range(1, 30);
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end
        end
    end

    // Receiver back-pressure: short stalls, short runs, and now and then a
    // long stretch of steady ready.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            ready_hold   <= 0;
        end
        else if (ready_hold > 0)
            ready_hold <= ready_hold - 1;
        else if (rsp_ch.ready)
        begin
            rsp_ch.ready <= 1'b0;
            ready_hold   <= $urandom_range(0, 5);
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
            ready_hold   <= ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                        : $urandom_range(0, 6);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each result against the oldest owed one, then runs the
    // predictor on any item taken at this edge. A result can never belong to
    // an item taken at the same edge, so this order is safe.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            bit moved;
            moved = 1'b0;
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                moved = 1'b1;
                if (owed_results.size() == 0)
                    report_mismatch($sformatf("result with none owed (value_out %0d status %0d)",
                                              rsp_ch.value_out, rsp_ch.status));
                else
                begin
                    queue_rsp_t want;
                    want = owed_results.pop_front();
                    if (rsp_ch.value_out !== want.value_out)
                        report_mismatch($sformatf("value_out %0d, expected %0d",
                                                  rsp_ch.value_out, want.value_out));
                    if (rsp_ch.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  rsp_ch.status, want.status));
                    status_seen[want.status]++;
                end
                result_count++;
            end
            if (req_ch.valid && req_ch.ready)
            begin
                moved = 1'b1;
                owed_results.push_back(predict_queue_op(req_ch.command, req_ch.value));
            end
            drained      <= (owed_results.size() == 0);
            quiet_cycles <= moved ? 0 : quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    initial
    begin
        int made;
        int enq_pct;
        int phase_len;
        bit first_phase;

        // channel signals are cleared by the driver and receiver resets
        rst_n          = 1'b0;
        entry_count    = 0;
        exit_count     = 0;
        error_count    = 0;
        result_count   = 0;
        refill_count   = 0;
        status_seen    = '{0, 0, 0, 0};
        quiet_cycles   = 0;
        drained        = 1'b1;
        timed_out      = 1'b0;

        // Directed: dequeue from empty, fill the entry stack to DEPTH with
        // edge values (the empty marker first, so it comes back as real data),
        // a refused enqueue, then a dequeue that moves a full stack across.
        add_item(CMD_DEQUEUE, 32'sd0, 1'b0);
        add_item(CMD_ENQUEUE, EMPTY_VALUE, 1'b0);
        add_item(CMD_ENQUEUE, 32'sh8000_0000, 1'b0);
        add_item(CMD_ENQUEUE, 32'sh7fff_ffff, 1'b0);
        add_item(CMD_ENQUEUE, 32'sd0, 1'b0);
        add_item(CMD_ENQUEUE, -32'sd1, 1'b0);
        add_item(CMD_ENQUEUE, 32'sd1, 1'b0);
        add_item(CMD_ENQUEUE, 32'sh5555_5555, 1'b0);
        add_item(CMD_ENQUEUE, 32'shaaaa_aaaa, 1'b0);
        for (int i = 8; i < DEPTH; i++)
            add_item(CMD_ENQUEUE, data_t'($urandom), 1'b0);
        add_item(CMD_ENQUEUE, 32'sh1234_5678, 1'b0);   // entry stack full: refused
        add_item(CMD_DEQUEUE, data_t'($urandom), 1'b0);
        add_item(CMD_ENQUEUE, -32'sd2, 1'b0);
        add_item(CMD_DEQUEUE, 32'sd0, 1'b0);
        add_item(CMD_DEQUEUE, 32'sd0, 1'b0);

        // Random phases, each with its own enqueue bias so the queue swings
        // between full and empty and refills come in all sizes. Some phases
        // start only after the block has gone quiet.
        made        = 0;
        first_phase = 1'b1;
        while (made < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 4))
                0: enq_pct = 10;
                1: enq_pct = 30;
                2: enq_pct = 50;
                3: enq_pct = 70;
                default: enq_pct = 90;
            endcase
            phase_len = $urandom_range(10, 60);
            for (int i = 0; i < phase_len && made < RANDOM_ITEMS; i++)
            begin
                add_item(($urandom_range(0, 99) < enq_pct) ? CMD_ENQUEUE : CMD_DEQUEUE,
                         pick_value(),
                         (i == 0) && (first_phase || $urandom_range(0, 5) == 0));
                made++;
            end
            first_phase = 1'b0;
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Sampled on the falling edge, away from the clocked blocks.
        while ((pending_items.size() != 0 || req_ch.valid || owed_results.size() != 0)
               && !timed_out)
        begin
            @(negedge clk);
            if (quiet_cycles >= QUIET_LIMIT)
                timed_out = 1'b1;
        end

        if (!timed_out)
        begin
            // let a late or spurious result show itself
            repeat (TAIL_CYCLES) @(posedge clk);
            @(negedge clk);
            if (owed_results.size() != 0)
                report_mismatch($sformatf("%0d results never arrived", owed_results.size()));
        end
        else
            $display("[%0t] no handshake for %0d cycles, %0d results still owed",
                     $realtime, QUIET_LIMIT, owed_results.size());

        $display("Checked %0d results: %0d enqueued, %0d refused as full, %0d dequeued, %0d empty.",
                 result_count, status_seen[ST_ENQUEUED], status_seen[ST_FULL],
                 status_seen[ST_DEQUEUED], status_seen[ST_EMPTY]);
        $display("Stack refills seen: %0d; mismatches: %0d.", refill_count, error_count);

        if (error_count == 0 && !timed_out)
            $display("** queue_from_two_stacks: PASSED **");
        else
            $display("** queue_from_two_stacks: FAILED **");
        $finish;
    end

endmodule
